FILE: design/lidar_frame_distance_zone_macros.svh
// ----------------------------------------------------------------------------
// lidar_frame_distance_zone_macros.svh
// Assertion macros shared by the range-finder frame parser modules.
// ----------------------------------------------------------------------------
`ifndef LIDAR_FRAME_DISTANCE_ZONE_MACROS_SVH
`define LIDAR_FRAME_DISTANCE_ZONE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define LFDZ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define LFDZ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lfdz_pkg.sv
// ----------------------------------------------------------------------------
// lfdz_pkg
// Types and constants for the range-finder frame parser.
// ----------------------------------------------------------------------------
package lfdz_pkg;

  localparam int FRAME_BYTES = 9;
  localparam int PIDX_W      = (FRAME_BYTES - 2 > 1) ? $clog2(FRAME_BYTES - 2) : 1;

  localparam logic [7:0]  HDR_BYTE        = 8'h59;
  localparam logic [15:0] FAR_LIMIT_RST   = 16'd200;
  localparam logic [15:0] MID_LIMIT_RST   = 16'd100;
  localparam logic [15:0] NEAR_LIMIT_RST  = 16'd60;

  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_FAR  = 2'd0;
  localparam logic [1:0] REG_MID  = 2'd1;
  localparam logic [1:0] REG_NEAR = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_SECOND  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ZONE_SAFE    = 2'd0,
    ZONE_CAUTION = 2'd1,
    ZONE_WARNING = 2'd2,
    ZONE_DANGER  = 2'd3
  } zone_t;

  typedef struct packed {
    logic        frame_done;
    logic [15:0] distance;
  } frame_t;

endpackage

FILE: design/lfdz_parser.sv
// ----------------------------------------------------------------------------
// lfdz_parser
// Header hunt and frame collection; flags the last byte of each frame and
// gives the distance assembled from frame bytes 2 and 3.
// ----------------------------------------------------------------------------
module lfdz_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_fire,
  input  logic [7:0]      rx_byte,
  output lfdz_pkg::frame_t frame
);
  import lfdz_pkg::*;
  `include "lidar_frame_distance_zone_macros.svh"

  localparam logic [PIDX_W-1:0] LAST_INDEX = PIDX_W'(FRAME_BYTES - 3);
  localparam logic [PIDX_W-1:0] LOW_INDEX  = PIDX_W'(0);
  localparam logic [PIDX_W-1:0] HIGH_INDEX = PIDX_W'(1);

  phase_t              phase, phase_next;
  logic [PIDX_W-1:0]   payload_index, payload_index_next;
  logic [7:0]          distance_low, distance_low_next;
  logic [15:0]         distance_word, distance_word_next;
  logic                done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      payload_index <= '0;
      distance_low  <= '0;
      distance_word <= '0;
    end else begin
      phase         <= phase_next;
      payload_index <= payload_index_next;
      distance_low  <= distance_low_next;
      distance_word <= distance_word_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    payload_index_next = payload_index;
    distance_low_next  = distance_low;
    distance_word_next = distance_word;
    done               = 1'b0;
    if (byte_fire) begin
      unique case (phase)
        PH_SECOND: begin
          if (rx_byte == HDR_BYTE) begin
            phase_next         = PH_PAYLOAD;
            payload_index_next = '0;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          if (payload_index == LOW_INDEX) begin
            distance_low_next = rx_byte;
          end else if (payload_index == HIGH_INDEX) begin
            distance_word_next = {rx_byte, distance_low};
          end
          if (payload_index >= LAST_INDEX) begin
            phase_next         = PH_HUNT;
            payload_index_next = '0;
            done               = 1'b1;
          end else begin
            payload_index_next = payload_index + PIDX_W'(1);
          end
        end
        default: begin
          phase_next = (rx_byte == HDR_BYTE) ? PH_SECOND : PH_HUNT;
        end
      endcase
    end
  end

  assign frame.frame_done = done;
  assign frame.distance   = distance_word_next;

  `LFDZ_ASSERT_NOW(a_done_in_payload, done,
    (phase == PH_PAYLOAD) && (payload_index == LAST_INDEX), "frame end outside payload")
  `LFDZ_ASSERT_NEXT(a_second_resolves, byte_fire && (phase == PH_SECOND),
    phase != PH_SECOND, "second header byte not resolved")
  `LFDZ_ASSERT_NOW(a_index_bound, phase == PH_PAYLOAD,
    payload_index <= LAST_INDEX, "payload index beyond frame")

endmodule

FILE: design/lidar_frame_distance_zone.sv
// ----------------------------------------------------------------------------
// lidar_frame_distance_zone
// Range-finder serial frame parser with proximity zone and LED drive.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while in_stall is low; the result of a frame
// is registered into the result register as its last byte is taken, or into
// the skid word if a held result still waits; throughput is one byte per clock.
// A two-word output stage (result register plus skid word) lets bytes keep
// flowing while a result waits; in_stall rises only once both are full.
// Thresholds are written over the APB port at 0x0 (far), 0x4 (mid), 0x8 (near).
// ----------------------------------------------------------------------------
module lidar_frame_distance_zone (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        rx_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [15:0]                       distance_cm,
  output logic [1:0]                        zone,
  output logic                              red_led,
  output logic                              grn_led,
  output logic                              red_blink,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lfdz_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import lfdz_pkg::*;
  `include "lidar_frame_distance_zone_macros.svh"

  logic [15:0] far_limit, mid_limit, near_limit;
  logic        cfg_wr;
  logic [1:0]  reg_sel;

  logic        in_fire, out_fire;
  frame_t      frame;
  zone_t       zone_new;

  zone_t       res_zone, skid_zone;
  logic [15:0] res_dist, skid_dist;
  logic        skid_valid;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      far_limit  <= FAR_LIMIT_RST;
      mid_limit  <= MID_LIMIT_RST;
      near_limit <= NEAR_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_FAR:  far_limit  <= pwdata[15:0];
        REG_MID:  mid_limit  <= pwdata[15:0];
        REG_NEAR: near_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FAR:  prdata = {16'd0, far_limit};
      REG_MID:  prdata = {16'd0, mid_limit};
      REG_NEAR: prdata = {16'd0, near_limit};
      default:  prdata = 32'd0;
    endcase
  end

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = skid_valid;

  lfdz_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_fire (in_fire),
    .rx_byte   (rx_byte),
    .frame     (frame)
  );

  // thresholds tested in order far, mid, near
  always_comb begin
    priority if (frame.distance > far_limit) begin
      zone_new = ZONE_SAFE;
    end else if (frame.distance > mid_limit) begin
      zone_new = ZONE_CAUTION;
    end else if (frame.distance > near_limit) begin
      zone_new = ZONE_WARNING;
    end else begin
      zone_new = ZONE_DANGER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (in_fire && frame.frame_done) begin
      if (out_valid && !out_fire) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        res_dist <= skid_dist;
        res_zone <= skid_zone;
      end
    end else if (in_fire && frame.frame_done) begin
      if (out_valid && !out_fire) begin
        skid_dist <= frame.distance;
        skid_zone <= zone_new;
      end else begin
        res_dist <= frame.distance;
        res_zone <= zone_new;
      end
    end
  end

  assign distance_cm = res_dist;
  assign zone        = res_zone;
  assign red_led     = (res_zone == ZONE_CAUTION) || (res_zone == ZONE_WARNING);
  assign grn_led     = (res_zone == ZONE_SAFE) || (res_zone == ZONE_CAUTION);
  assign red_blink   = (res_zone == ZONE_DANGER);

  `LFDZ_ASSERT_NOW(a_skid_needs_main, skid_valid, out_valid, "skid word without result")
  `LFDZ_ASSERT_NOW(a_led_exclusive, out_valid, $onehot0({red_blink, grn_led && !red_led}),
    "blink with green drive")
  `LFDZ_ASSERT_NEXT(a_skid_drains, skid_valid && out_fire, !skid_valid && out_valid,
    "skid word not moved on")

endmodule

FILE: tb/lidar_frame_distance_zone_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_frame_distance_zone_test
// Self-checking bench for the range-finder frame parser.
// ----------------------------------------------------------------------------
// Feeds serial bytes (a short hand-picked run, then random frames mixed with
// junk and broken headers) under several threshold settings written over APB.
// A scoreboard tracks the header hunt and payload position itself, works out
// the distance, zone and LED bits of every completed frame and compares them
// with each word leaving the block. The byte input idles and the result output stalls at random.
// ----------------------------------------------------------------------------
module lidar_frame_distance_zone_test;
  import lfdz_pkg::*;

  localparam int          STALL_PCT   = 14;
  localparam int          HOLD_CYCLES = 300;
  localparam int          SETTLE      = 8;
  localparam int          WDOG_LIMIT  = 2000;
  localparam logic [1:0]  REG_SPARE   = 2'd3;

  typedef struct packed {
    logic [15:0] distance_cm;
    zone_t       zone;
    logic        red_led;
    logic        grn_led;
    logic        red_blink;
  } reading_t;

  class frame_zone_scoreboard;
    logic [15:0] far_lim;
    logic [15:0] mid_lim;
    logic [15:0] near_lim;
    phase_t      phase;
    int unsigned pidx;
    logic [7:0]  dist_low;
    logic [15:0] dist_word;
    reading_t    due_readings[$];
    int unsigned fail_count;

    function new();
      far_lim    = FAR_LIMIT_RST;
      mid_lim    = MID_LIMIT_RST;
      near_lim   = NEAR_LIMIT_RST;
      phase      = PH_HUNT;
      pidx       = 0;
      dist_low   = '0;
      dist_word  = '0;
      fail_count = 0;
    endfunction

    function void set_limit(logic [1:0] idx, logic [15:0] v);
      case (idx)
        REG_FAR:  far_lim = v;
        REG_MID:  mid_lim = v;
        REG_NEAR: near_lim = v;
        default: ;
      endcase
    endfunction

    function reading_t classify_distance(logic [15:0] d);
      reading_t r;
      r.distance_cm = d;
      if (d > far_lim) r.zone = ZONE_SAFE;
      else if (d > mid_lim) r.zone = ZONE_CAUTION;
      else if (d > near_lim) r.zone = ZONE_WARNING;
      else r.zone = ZONE_DANGER;
      r.red_led   = (r.zone == ZONE_CAUTION) || (r.zone == ZONE_WARNING);
      r.grn_led   = (r.zone == ZONE_SAFE) || (r.zone == ZONE_CAUTION);
      r.red_blink = (r.zone == ZONE_DANGER);
      return r;
    endfunction

    function void note_byte(logic [7:0] b);
      int unsigned pos;
      case (phase)
        PH_SECOND: begin
          if (b == HDR_BYTE) begin
            phase = PH_PAYLOAD;
            pidx  = 0;
          end else begin
            phase = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          pos = pidx + 2;
          if (pos == 2) dist_low = b;
          else if (pos == 3) dist_word = {b, dist_low};
          if (pos + 1 >= FRAME_BYTES) begin
            phase = PH_HUNT;
            pidx  = 0;
            due_readings.push_back(classify_distance(dist_word));
          end else begin
            pidx = pidx + 1;
          end
        end
        default: phase = (b == HDR_BYTE) ? PH_SECOND : PH_HUNT;
      endcase
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (due_readings.size() == 0) begin
        if (fail_count < 10)
          $display("%0t: unexpected word dist=%0d zone=%0d r=%b g=%b blink=%b", $realtime,
                   got.distance_cm, got.zone, got.red_led, got.grn_led, got.red_blink);
        fail_count++;
        return;
      end
      want = due_readings.pop_front();
      if (got.distance_cm !== want.distance_cm || got.zone !== want.zone ||
          got.red_led !== want.red_led || got.grn_led !== want.grn_led ||
          got.red_blink !== want.red_blink) begin
        if (fail_count < 10)
          $display("%0t: exp d=%0d z=%0d r=%b g=%b b=%b, got d=%0d z=%0d r=%b g=%b b=%b",
                   $realtime, want.distance_cm, want.zone, want.red_led, want.grn_led,
                   want.red_blink, got.distance_cm, got.zone, got.red_led, got.grn_led,
                   got.red_blink);
        fail_count++;
      end
    endfunction

    function int unsigned waiting();
      return due_readings.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            rx_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [15:0]           distance_cm;
  logic [1:0]            zone;
  logic                  red_led;
  logic                  grn_led;
  logic                  red_blink;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  bit                    quiet = 1'b0;
  bit                    hold_req = 1'b0;
  int unsigned           idle_cycles = 0;
  frame_zone_scoreboard  sb = new();

  lidar_frame_distance_zone dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .distance_cm(distance_cm), .zone(zone), .red_led(red_led),
    .grn_led(grn_led), .red_blink(red_blink),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // handshake monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_reading('{distance_cm, zone_t'(zone), red_led, grn_led, red_blink});
      if (in_valid && !in_stall)
        sb.note_byte(rx_byte);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("%0t: timeout, %0d words outstanding", $realtime, sb.waiting());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // result side stall, with a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < STALL_PCT);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!quiet) begin
      while ($urandom_range(99) < STALL_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_frame(input logic [15:0] d);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(d[7:0]);
    send_byte(d[15:8]);
    repeat (FRAME_BYTES - 4) send_byte(8'($urandom));
  endtask

  task automatic send_junk();
    logic [7:0] b;
    if ($urandom_range(9) < 3) begin
      // broken header
      send_byte(HDR_BYTE);
      do b = 8'($urandom); while (b == HDR_BYTE);
      send_byte(b);
    end else begin
      repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
    end
  endtask

  function automatic logic [15:0] pick_distance();
    logic [15:0] base;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        case ($urandom_range(2))
          0: base = sb.far_lim;
          1: base = sb.mid_lim;
          default: base = sb.near_lim;
        endcase
        return base + 16'($urandom_range(2)) - 16'd1;
      end
      6: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      7: return 16'($urandom_range(400));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_random(input int frames);
    int sent;
    sent = 0;
    while (sent < frames) begin
      if ($urandom_range(9) < 8) begin
        send_frame(pick_distance());
        sent++;
      end else begin
        send_junk();
      end
    end
    in_valid <= 1'b0;
  endtask

  // the edge that took the last byte is seen by the monitor first
  task automatic drain();
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= {16'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_limit(idx, v);
  endtask

  task automatic set_thresholds(input logic [15:0] far_v, input logic [15:0] mid_v,
                                input logic [15:0] near_v);
    apb_write(REG_FAR, far_v);
    apb_write(REG_MID, mid_v);
    apb_write(REG_NEAR, near_v);
    @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // hand-picked run at reset thresholds
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_BYTE);
    send_byte(8'h12);
    send_frame(16'hFFFF);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    repeat (FRAME_BYTES - 4) send_byte(8'h00);
    send_frame(16'h0000);
    in_valid <= 1'b0;
    drain();

    set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(12);
    drain();

    set_thresholds(16'h0000, 16'h0000, 16'h0000);
    hold_req = 1'b1;
    run_random(14);
    drain();

    set_thresholds(16'd500, 16'd300, 16'd40);
    apb_write(REG_SPARE, 16'd7);
    quiet = 1'b1;
    run_random(16);
    drain();
    quiet = 1'b0;

    set_thresholds(16'd1000, 16'd50, 16'd300);
    run_random(12);
    drain();

    set_thresholds(FAR_LIMIT_RST, MID_LIMIT_RST, NEAR_LIMIT_RST);
    run_random(16);
    drain();

    if (sb.fail_count == 0 && sb.waiting() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/lfdz_pkg.sv
design/lfdz_parser.sv
design/lidar_frame_distance_zone.sv
tb/lidar_frame_distance_zone_test.sv
